// File: hw/rtl/tf512_pkg.sv
// ----------------------------------------------------------------------------
// tf512_pkg
// Shared types, constants and round helpers for the Threefish-512 keystream core.
// ----------------------------------------------------------------------------
package tf512_pkg;

	localparam int unsigned NUM_ROUNDS = 72;
	localparam logic [63:0] KEY_PARITY = 64'h5555555555555555;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_TWEAK = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	typedef logic [63:0] word_t;
	typedef word_t [7:0] block_t;

	// datapath commands from the controller
	typedef struct packed {
		logic load_key;
		logic load_tweak;
		logic start;
		logic blk_init;
		logic blk_round;
		logic blk_final;
		logic emit;
		logic use_held;
	} cmd_t;

	typedef struct packed {
		logic need_block;
		logic rounds_done;
	} status_t;

	function automatic word_t rotl(input word_t x, input logic [5:0] r);
		logic [127:0] d;
		d = {x, x} << r;
		return d[127:64];
	endfunction

	// reduce modulo 9; v stays below 27
	function automatic logic [3:0] mod9(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (r >= 5'd18) r = r - 5'd18;
		else if (r >= 5'd9) r = r - 5'd9;
		return r[3:0];
	endfunction

	// reduce modulo 3; v stays below 27
	function automatic logic [1:0] mod3(input logic [4:0] v);
		logic [3:0] m;
		m = mod9(v);
		if (m >= 4'd6) m = m - 4'd6;
		else if (m >= 4'd3) m = m - 4'd3;
		return m[1:0];
	endfunction

	function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] j);
		logic [5:0] v;
		unique case ({r, j})
			5'd0: v = 6'd46; 5'd1: v = 6'd36; 5'd2: v = 6'd19; 5'd3: v = 6'd37;
			5'd4: v = 6'd33; 5'd5: v = 6'd27; 5'd6: v = 6'd14; 5'd7: v = 6'd42;
			5'd8: v = 6'd17; 5'd9: v = 6'd49; 5'd10: v = 6'd36; 5'd11: v = 6'd39;
			5'd12: v = 6'd44; 5'd13: v = 6'd9; 5'd14: v = 6'd54; 5'd15: v = 6'd56;
			5'd16: v = 6'd39; 5'd17: v = 6'd30; 5'd18: v = 6'd34; 5'd19: v = 6'd24;
			5'd20: v = 6'd13; 5'd21: v = 6'd50; 5'd22: v = 6'd10; 5'd23: v = 6'd17;
			5'd24: v = 6'd25; 5'd25: v = 6'd29; 5'd26: v = 6'd39; 5'd27: v = 6'd43;
			5'd28: v = 6'd8; 5'd29: v = 6'd35; 5'd30: v = 6'd56; 5'd31: v = 6'd22;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/tf512_if.sv
// ----------------------------------------------------------------------------
// tf512_in_if / tf512_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface tf512_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  word_index;
	logic [63:0] word_value;
	logic [7:0]  data_byte;
	modport source (output valid, kind, word_index, word_value, data_byte, input ready);
	modport sink (input valid, kind, word_index, word_value, data_byte, output ready);
endinterface

interface tf512_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	modport source (output valid, out_byte, input ready);
	modport sink (input valid, out_byte, output ready);
endinterface

// File: hw/rtl/threefish512_ctr_keystream_xor_core.sv
// ----------------------------------------------------------------------------
// threefish512_ctr_keystream_xor_core
// Threefish-512 counter-mode byte stream cipher with valid/ready channels.
// ----------------------------------------------------------------------------
// Load and start items are taken while the controller is idle. A data byte that falls
// inside the current keystream block is emitted directly; the first byte of each block
// waits while the single round unit runs 72 rounds (one per cycle) and then the final
// key add. Each result sits in an output register; a new item is taken whenever the
// controller is idle and that register is free or drains.
module threefish512_ctr_keystream_xor_core (
	input  logic clk,
	input  logic arst_n,
	tf512_in_if.sink    in_ch,
	tf512_out_if.source out_ch
);
	tf512_pkg::cmd_t    cmd;
	tf512_pkg::status_t status;
	logic               out_free;

	assign out_free = !out_ch.valid || out_ch.ready;

	tf512_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
		.out_free(out_free), .status(status), .cmd(cmd)
	);

	tf512_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.word_index(in_ch.word_index), .word_value(in_ch.word_value),
		.data_byte(in_ch.data_byte), .status(status),
		.out_valid(out_ch.valid), .out_byte(out_ch.out_byte), .out_ready(out_ch.ready)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.blk_init, cmd.blk_round, cmd.blk_final}) <= 1)
		else $error("block commands overlap");
	a_final_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blk_final |=> cmd.emit)
		else $error("block finished without emit");
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blk_round |-> !in_ch.ready)
		else $error("input taken during rounds");
endmodule

// File: hw/rtl/tf512_ctrl.sv
// ----------------------------------------------------------------------------
// tf512_ctrl
// Controller: accepts items, sequences block generation, issues byte emits.
// ----------------------------------------------------------------------------
module tf512_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_kind,
	output logic                in_ready,
	input  logic                out_free,
	input  tf512_pkg::status_t  status,
	output tf512_pkg::cmd_t     cmd
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.load_key   = acc && (in_kind == tf512_pkg::KIND_KEY);
		cmd.load_tweak = acc && (in_kind == tf512_pkg::KIND_TWEAK);
		cmd.start      = acc && (in_kind == tf512_pkg::KIND_START);
		cmd.blk_init   = acc && (in_kind == tf512_pkg::KIND_DATA) && status.need_block;
		cmd.blk_round  = (state_q == ST_ROUND);
		cmd.blk_final  = (state_q == ST_FINAL);
		cmd.emit       = (acc && (in_kind == tf512_pkg::KIND_DATA) && !status.need_block)
			|| (state_q == ST_EMIT);
		cmd.use_held   = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (cmd.blk_init) state_q <= ST_ROUND;
				ST_ROUND: if (status.rounds_done) state_q <= ST_FINAL;
				ST_FINAL: state_q <= ST_EMIT;
				ST_EMIT:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/tf512_datapath.sv
// ----------------------------------------------------------------------------
// tf512_datapath
// Key schedule storage, one-round-per-cycle Threefish engine, byte selection.
// ----------------------------------------------------------------------------
module tf512_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tf512_pkg::cmd_t     cmd,
	input  logic [2:0]          word_index,
	input  logic [63:0]         word_value,
	input  logic [7:0]          data_byte,
	output tf512_pkg::status_t  status,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	input  logic                out_ready
);
	tf512_pkg::word_t key_q [9];
	tf512_pkg::word_t tweak_q [3];
	tf512_pkg::word_t ctr_q;
	tf512_pkg::block_t rw_q, ks_q, rw_in, rw_next, sk;
	logic [6:0] pos_q, rnd_q;
	logic [4:0] s_idx;
	logic [7:0] byte_hold_q, ksb;
	logic [63:0] par;

	// subkey number; rounds after add step on count/4, final uses 18
	assign s_idx = cmd.blk_final ? 5'd18 : rnd_q[6:2];

	always_comb begin
		logic [1:0] t;
		for (int i = 0; i < 8; i++)
			sk[i] = key_q[tf512_pkg::mod9(s_idx + 5'(i))];
		t = tf512_pkg::mod3(s_idx);
		sk[5] = sk[5] + tweak_q[t];
		t = tf512_pkg::mod3(s_idx + 5'd1);
		sk[6] = sk[6] + tweak_q[t];
		sk[7] = sk[7] + 64'(s_idx);
	end

	always_comb begin
		tf512_pkg::block_t m;
		tf512_pkg::word_t a;
		for (int i = 0; i < 8; i++)
			rw_in[i] = (rnd_q[1:0] == 2'd0) ? rw_q[i] + sk[i] : rw_q[i];
		for (int j = 0; j < 4; j++) begin
			a = rw_in[2*j] + rw_in[2*j+1];
			m[2*j] = a;
			m[2*j+1] = tf512_pkg::rotl(rw_in[2*j+1],
				tf512_pkg::rot_amt(rnd_q[2:0], 2'(j))) ^ a;
		end
		rw_next[0] = m[2]; rw_next[1] = m[1]; rw_next[2] = m[4]; rw_next[3] = m[7];
		rw_next[4] = m[6]; rw_next[5] = m[5]; rw_next[6] = m[0]; rw_next[7] = m[3];
	end

	always_comb begin
		par = tf512_pkg::KEY_PARITY;
		for (int i = 0; i < 8; i++) par = par ^ key_q[i];
	end

	assign status.need_block  = pos_q[6];
	assign status.rounds_done = (rnd_q == 7'(tf512_pkg::NUM_ROUNDS - 1));

	assign ksb = ks_q[pos_q[5:3]][8*pos_q[2:0] +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) key_q[i] <= '0;
			for (int i = 0; i < 3; i++) tweak_q[i] <= '0;
			ctr_q <= '0;
			pos_q <= 7'd64;
			rnd_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_key) key_q[{1'b0, word_index}] <= word_value;
			if (cmd.load_tweak && word_index < 3'd2)
				tweak_q[{1'b0, word_index[0]}] <= word_value;
			if (cmd.start) begin
				key_q[8] <= par;
				tweak_q[2] <= tweak_q[0] ^ tweak_q[1];
				ctr_q <= '0;
				pos_q <= 7'd64;
			end
			if (cmd.blk_init) rnd_q <= '0;
			if (cmd.blk_round) rnd_q <= rnd_q + 7'd1;
			if (cmd.blk_final) begin
				ctr_q <= ctr_q + 64'd1;
				pos_q <= '0;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				pos_q <= pos_q + 7'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blk_init) begin
			rw_q <= tf512_pkg::block_t'({448'd0, ctr_q});
			byte_hold_q <= data_byte;
		end
		if (cmd.blk_round) rw_q <= rw_next;
		if (cmd.blk_final)
			for (int i = 0; i < 8; i++) ks_q[i] <= rw_q[i] + sk[i];
		if (cmd.emit) out_byte <= (cmd.use_held ? byte_hold_q : data_byte) ^ ksb;
	end
endmodule

// File: bench/tb_threefish512_ctr_keystream_xor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threefish512_ctr_keystream_xor_checker
// Watches both channels, keeps its own Threefish-512 counter-mode state and
// compares every output byte with the predicted keystream XOR.
// ----------------------------------------------------------------------------
module tb_threefish512_ctr_keystream_xor_checker (
	input  logic        clk,
	input  logic        arst_n,
	tf512_in_if.sink    in_mon,
	tf512_out_if.sink   out_mon,
	output int          fail_count,
	output int          pending
);

	tf512_pkg::word_t keys [0:8];
	tf512_pkg::word_t tweaks [0:2];
	tf512_pkg::word_t ctr;
	tf512_pkg::word_t ks [0:7];
	int        pos;
	logic [7:0] cipher_q [$];

	function automatic tf512_pkg::word_t rotate_left(tf512_pkg::word_t x, int r);
		if (r == 0)
			return x;
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic int rot_of(int r, int j);
		int t [0:31];
		t = '{46, 36, 19, 37, 33, 27, 14, 42, 17, 49, 36, 39, 44, 9, 54, 56,
			39, 30, 34, 24, 13, 50, 10, 17, 25, 29, 39, 43, 8, 35, 56, 22};
		return t[r * 4 + j];
	endfunction

	task automatic inject_subkey(inout tf512_pkg::word_t w [0:7], input int s);
		for (int i = 0; i < 8; i++)
			w[i] += keys[(s + i) % 9];
		w[5] += tweaks[s % 3];
		w[6] += tweaks[(s + 1) % 3];
		w[7] += tf512_pkg::word_t'(s);
	endtask

	task automatic encrypt_counter();
		tf512_pkg::word_t w [0:7];
		tf512_pkg::word_t m [0:7];
		int perm [0:7];
		perm = '{2, 1, 4, 7, 6, 5, 0, 3};
		for (int i = 0; i < 8; i++)
			w[i] = '0;
		w[0] = ctr;
		for (int rc = 0; rc < tf512_pkg::NUM_ROUNDS; rc++) begin
			if (rc % 4 == 0)
				inject_subkey(w, rc / 4);
			for (int i = 0; i < 4; i++) begin
				m[2*i] = w[2*i] + w[2*i+1];
				m[2*i+1] = rotate_left(w[2*i+1], rot_of(rc % 8, i)) ^ m[2*i];
			end
			for (int i = 0; i < 8; i++)
				w[i] = m[perm[i]];
		end
		inject_subkey(w, tf512_pkg::NUM_ROUNDS / 4);
		for (int i = 0; i < 8; i++)
			ks[i] = w[i];
		ctr += 1;
		pos = 0;
	endtask

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		tf512_pkg::word_t par;
		logic [7:0] got;
		logic [7:0] want;
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				keys[i] = '0;
			for (int i = 0; i < 3; i++)
				tweaks[i] = '0;
			ctr = '0;
			pos = 64;
			fail_count = 0;
			cipher_q.delete();
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.out_byte;
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected out_byte, expected none, actual %02h", $time, got);
					fail_count++;
				end else begin
					want = cipher_q.pop_front();
					if (got !== want) begin
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, want, got);
						fail_count++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				case (in_mon.kind)
					tf512_pkg::KIND_KEY: keys[in_mon.word_index] = in_mon.word_value;
					tf512_pkg::KIND_TWEAK: if (in_mon.word_index < 2)
						tweaks[in_mon.word_index] = in_mon.word_value;
					tf512_pkg::KIND_START: begin
						par = tf512_pkg::KEY_PARITY;
						for (int i = 0; i < 8; i++)
							par ^= keys[i];
						keys[8] = par;
						tweaks[2] = tweaks[0] ^ tweaks[1];
						ctr = '0;
						pos = 64;
					end
					default: begin
						if (pos >= 64)
							encrypt_counter();
						cipher_q.push_back(in_mon.data_byte ^ ks[pos / 8][(pos % 8) * 8 +: 8]);
						pos++;
					end
				endcase
			end
		end
	end

endmodule

// File: bench/tb_threefish512_ctr_keystream_xor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threefish512_ctr_keystream_xor_core
// Drives key, tweak, start and data items with random gaps and output stalls;
// the checker predicts each output byte and counts mismatches.
// ----------------------------------------------------------------------------
module tb_threefish512_ctr_keystream_xor_core;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   calm = 0;
	bit   hold_long = 0;

	tf512_in_if  in_ch ();
	tf512_out_if out_ch ();

	threefish512_ctr_keystream_xor_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	tb_threefish512_ctr_keystream_xor_checker chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.kind = tf512_pkg::KIND_KEY;
		in_ch.word_index = 0;
		in_ch.word_value = 0;
		in_ch.data_byte = 0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("** threefish512_ctr_keystream_xor_core: FAILED **");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off, steady at the end
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(3) == 0) begin
				n = $urandom_range(1, 11);
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				out_ch.ready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic send(logic [1:0] k, logic [2:0] idx, tf512_pkg::word_t v, logic [7:0] b);
		int n;
		if (!calm && $urandom_range(4) == 0) begin
			n = $urandom_range(1, 11);
			in_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.kind <= k;
		in_ch.word_index <= idx;
		in_ch.word_value <= v;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic tf512_pkg::word_t rand_word();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic load_keys();
		for (int i = 0; i < 8; i++)
			send(tf512_pkg::KIND_KEY, 3'(i), rand_word(), 0);
		send(tf512_pkg::KIND_TWEAK, 0, rand_word(), 0);
		send(tf512_pkg::KIND_TWEAK, 1, rand_word(), 0);
	endtask

	initial begin
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: data before any start, extremes, ignored tweak index
		send(tf512_pkg::KIND_DATA, 7, '1, 8'h00);
		send(tf512_pkg::KIND_DATA, 0, '0, 8'hff);
		send(tf512_pkg::KIND_TWEAK, 2, '1, 0);
		send(tf512_pkg::KIND_TWEAK, 7, '1, 0);
		send(tf512_pkg::KIND_KEY, 7, '1, 0);
		send(tf512_pkg::KIND_KEY, 0, 64'h8000000000000001, 0);
		send(tf512_pkg::KIND_TWEAK, 1, '1, 0);
		send(tf512_pkg::KIND_START, 0, 0, 0);
		send(tf512_pkg::KIND_DATA, 0, 0, 8'ha5);
		send(tf512_pkg::KIND_KEY, 3, 64'h0123456789abcdef, 0); // parity word refreshed only at next start
		send(tf512_pkg::KIND_DATA, 0, 0, 8'h5a);
		send(tf512_pkg::KIND_START, 0, 0, 0);
		send(tf512_pkg::KIND_DATA, 0, 0, 8'h00);
		// random: mostly full loads then a message, with some noise items
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 2)
				hold_long = 1;
			if (phase == 10)
				calm = 1;
			if ($urandom_range(3) != 0)
				load_keys();
			else
				send(2'($urandom_range(1)), 3'($urandom), rand_word(), 0);
			send(tf512_pkg::KIND_START, 3'($urandom), rand_word(), 0);
			len = (phase % 6 == 0) ? 130 : $urandom_range(1, 40);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(30) == 0)
					send(2'($urandom_range(1)), 3'($urandom), rand_word(), 8'($urandom));
				send(tf512_pkg::KIND_DATA, 3'($urandom), rand_word(), 8'($urandom));
			end
		end
		in_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** threefish512_ctr_keystream_xor_core: PASSED **");
		else
			$display("** threefish512_ctr_keystream_xor_core: FAILED **");
		$finish;
	end

endmodule
